>>> hdl/u8u16_pkg.sv
// u8u16_pkg: shared types and constants for the UTF-8 to UTF-16BE stream converter.
// Used by utf8_to_utf16be_stream and its port checker; no dependencies.
`default_nettype none

package u8u16_pkg;

    localparam int unsigned MAX_RES = 3;

    localparam logic [7:0] ASCII_MAX = 8'h7E;
    localparam logic [7:0] TERM_HI   = 8'hFF;
    localparam logic [7:0] TERM_LO   = 8'hFE;
    localparam logic [1:0] CONT_TAG  = 2'b10;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_COLLECT = 3'd1,
        PH_SKIP    = 3'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_error;
        logic       is_end;
        logic       last_of_run;
    } t_result;

    localparam t_result RES_NONE  = '{out_byte: 8'h00, is_error: 1'b0, is_end: 1'b0,
                                      last_of_run: 1'b0};
    localparam t_result RES_ERROR = '{out_byte: 8'h00, is_error: 1'b1, is_end: 1'b0,
                                      last_of_run: 1'b1};

endpackage

`default_nettype wire

>>> hdl/utf8_to_utf16be_stream.sv
// The result words are registered: the first is valid in the cycle after the input word is accepted.
// An input word gives 0..3 result words, and o_stall holds off the next input word while result
// words remain; it can be taken in the cycle the last pending result word is taken.
// Reset (synchronous, active low) returns the decoder to idle with no pending results.
// Top level: decoder state, result buffer of three words; uses u8u16_pkg.
`default_nettype none

module utf8_to_utf16be_stream
    import u8u16_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_data_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_is_error,
    output logic            o_is_end,
    output logic            o_last_of_run
);

    t_phase     r_phase,      n_phase;
    logic [1:0] r_bytes_left, n_bytes_left;
    logic [1:0] r_seq_length, n_seq_length;
    logic [7:0] r_held [MAX_RES];
    logic [7:0] n_held [MAX_RES];

    t_result    r_res [MAX_RES];
    logic [1:0] r_cnt;

    t_result    res [MAX_RES];
    logic [1:0] res_cnt;
    logic [1:0] held_idx;
    logic       in_acc;
    logic       out_acc;

    assign out_acc = (r_cnt != 2'd0) && !i_stall;
    assign o_stall = !((r_cnt == 2'd0) || ((r_cnt == 2'd1) && !i_stall));
    assign in_acc  = i_valid && !o_stall;

    assign o_valid       = (r_cnt != 2'd0);
    assign o_out_byte    = r_res[0].out_byte;
    assign o_is_error    = r_res[0].is_error;
    assign o_is_end      = r_res[0].is_end;
    assign o_last_of_run = r_res[0].last_of_run;

    assign held_idx = r_seq_length - r_bytes_left + 2'd1;

    // next decoder state
    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_seq_length = r_seq_length;
        n_held       = r_held;
        if (in_acc) begin
            case (r_phase)
                PH_SKIP: begin
                    if (i_data_byte == 8'h00) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_COLLECT: begin
                    if (i_data_byte[7:6] != CONT_TAG) begin
                        n_phase      = (i_data_byte == 8'h00) ? PH_IDLE : PH_SKIP;
                        n_bytes_left = 2'd0;
                    end else if (r_bytes_left > 2'd1) begin
                        if (held_idx == 2'd1) begin
                            n_held[1] = i_data_byte;
                        end else begin
                            n_held[2] = i_data_byte;
                        end
                        n_bytes_left = r_bytes_left - 2'd1;
                    end else begin
                        n_phase      = PH_IDLE;
                        n_bytes_left = 2'd0;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    case (i_data_byte) inside
                        8'b110?????, 8'b1110????, 8'b11110???: begin
                            if (i_data_byte[7:5] == 3'b110) begin
                                n_seq_length = 2'd1;
                            end else if (i_data_byte[7:4] == 4'b1110) begin
                                n_seq_length = 2'd2;
                            end else begin
                                n_seq_length = 2'd3;
                            end
                            n_held[0]    = i_data_byte;
                            n_held[1]    = 8'h00;
                            n_held[2]    = 8'h00;
                            n_bytes_left = n_seq_length;
                            n_phase      = PH_COLLECT;
                        end
                        [8'h00:ASCII_MAX]: begin
                            n_phase = PH_IDLE;
                        end
                        default: begin
                            n_phase = PH_SKIP;
                        end
                    endcase
                end
            endcase
        end
    end

    // result words for the current input word
    always_comb begin
        res[0]  = RES_NONE;
        res[1]  = RES_NONE;
        res[2]  = RES_NONE;
        res_cnt = 2'd0;
        case (r_phase)
            PH_SKIP: begin
                res_cnt = 2'd0;
            end
            PH_COLLECT: begin
                if (i_data_byte[7:6] != CONT_TAG) begin
                    res[0]  = RES_ERROR;
                    res_cnt = 2'd1;
                end else if (r_bytes_left > 2'd1) begin
                    res_cnt = 2'd0;
                end else if (r_seq_length == 2'd1) begin
                    res[0].out_byte    = {5'b0, r_held[0][4:2]};
                    res[1].out_byte    = {r_held[0][1:0], i_data_byte[5:0]};
                    res[1].last_of_run = 1'b1;
                    res_cnt            = 2'd2;
                end else if (r_seq_length == 2'd2) begin
                    res[0].out_byte    = {r_held[0][3:0], r_held[1][5:2]};
                    res[1].out_byte    = {r_held[1][1:0], i_data_byte[5:0]};
                    res[1].last_of_run = 1'b1;
                    res_cnt            = 2'd2;
                end else begin
                    res[0].out_byte    = {3'b0, r_held[0][2:0], r_held[1][5:4]};
                    res[1].out_byte    = {r_held[1][3:0], r_held[2][5:2]};
                    res[2].out_byte    = {r_held[2][1:0], i_data_byte[5:0]};
                    res[2].last_of_run = 1'b1;
                    res_cnt            = 2'd3;
                end
            end
            default: begin
                case (i_data_byte) inside
                    8'h00: begin
                        res[0].out_byte    = TERM_HI;
                        res[1].out_byte    = TERM_LO;
                        res[1].is_end      = 1'b1;
                        res[1].last_of_run = 1'b1;
                        res_cnt            = 2'd2;
                    end
                    [8'h01:ASCII_MAX]: begin
                        res[1].out_byte    = i_data_byte;
                        res[1].last_of_run = 1'b1;
                        res_cnt            = 2'd2;
                    end
                    8'b110?????, 8'b1110????, 8'b11110???: begin
                        res_cnt = 2'd0;
                    end
                    default: begin
                        res[0]  = RES_ERROR;
                        res_cnt = 2'd1;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bytes_left <= 2'd0;
            r_seq_length <= 2'd0;
        end else begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_seq_length <= n_seq_length;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

    // result buffer: head word drives the outputs, shifts on each take unless a new input word loads it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (in_acc) begin
            r_cnt <= res_cnt;
        end else if (out_acc) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res <= res;
        end else if (out_acc) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

endmodule

`default_nettype wire

>>> hdl/u8u16_checker.sv
// u8u16_checker: port-level assertions for utf8_to_utf16be_stream, bound to the top level.
// Sees only the top level's ports; uses u8u16_pkg for the terminator constant TERM_LO.
`default_nettype none

module u8u16_checker
    import u8u16_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_is_error,
    input wire logic       o_is_end,
    input wire logic       o_last_of_run
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_is_error)
            && $stable(o_is_end) && $stable(o_last_of_run))
        else $error("stalled output word changed");

    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_error |-> o_out_byte == 8'h00 && !o_is_end && o_last_of_run)
        else $error("malformed error word");

    a_end_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_end |-> o_out_byte == TERM_LO && o_last_of_run && !o_is_error)
        else $error("malformed end word");

    // input held off until the run is complete
    a_run_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run |-> o_stall)
        else $error("input taken mid-run");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run && !i_stall |=> o_valid)
        else $error("run broken off");

endmodule

bind utf8_to_utf16be_stream u8u16_checker u_u8u16_checker (.*);

`default_nettype wire
